// File: hdl/rgba_convolution_filter_defines.svh
// ---------------------------------------------------------------------------
// rgba_convolution_filter_defines: assertion macros for the filter
// Shared concurrent check forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef RGBA_CONVOLUTION_FILTER_DEFINES_SVH
`define RGBA_CONVOLUTION_FILTER_DEFINES_SVH

// same-cycle implication
`define RCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcf check failed");

// next-cycle implication
`define RCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcf check failed");

`endif

// File: hdl/rcf_pkg.sv
// ---------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the RGBA convolution filter
// Request and result payloads, job format, geometry and state encodings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcf_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 17;
  localparam int unsigned POS_W     = 27;
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned RAM_DEPTH = 4096;
  localparam int unsigned TAPS      = 9;
  localparam int unsigned ACC_W     = 29;
  localparam int unsigned PROD_W    = 45;
  localparam int unsigned GAIN_FRAC = 12;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_COEF  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_GAIN   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_DIV,
    F_RUN
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TAP,
    B_LAST,
    B_SCALE,
    B_PUSH
  } back_state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
    logic [3:0]         coef_index;
    logic signed [15:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic               is_coef;
    logic [3:0]         coef_idx;
    logic signed [15:0] coef_val;
    logic [ROW_W-1:0]   qrow;
    logic [COL_W-1:0]   qcol;
    logic               last;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic [10:0]      w_eff;
    logic [15:0]      h_eff;
    logic [POS_W-1:0] npix;
    logic [POS_W-1:0] lag;
    logic [POS_W-1:0] total;
  } geom_t;

endpackage

// File: hdl/rgba_convolution_filter.sv
// RGBA 3x3 convolution filter.
// Input queue: push request items (pixel, coefficient write, flush) while
// full is low. Result queue: the oldest result sits on result_o while
// empty is low and leaves with pop. Registers (width, height, gain) are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write
// them only while the block is idle, and the block does not enforce it.
// Each output pixel passes through the datapath as nine line-store reads
// through the single read port, then gain, clamp and queueing. Intake
// accepts at most one further raster item while a job is in flight, so once
// output starts raster intake waits on the datapath; warm-up items queue no job.
// Output lags input by one row plus one pixel; flush items drain the frame.
// After reset the line store is cleared word by word, with full held high.
// A width write starts a position recompute, with full held high.
// A stalled receiver fills the two-entry result queue, then the datapath
// and the job queue stop, and full rises.
// ---------------------------------------------------------------------------
// rgba_convolution_filter: top level
// Configuration registers, geometry, line store and the three parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgba_convolution_filter_defines.svh"

module rgba_convolution_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  rcf_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output rcf_pkg::out_item_t result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  logic [10:0]        width_q;
  logic [15:0]        height_q;
  logic signed [15:0] gain_q;
  rcf_pkg::geom_t     geom;
  logic               wstart;
  logic [1:0]         pending, jq_cnt;
  logic               jq_full, jq_valid, jq_pop, job_push, back_busy;
  rcf_pkg::job_t      job_in, job_out;
  rcf_pkg::ram_wr_t   ram_wr;
  logic [rcf_pkg::ADDR_W-1:0] raddr;
  logic [31:0]        rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 16'd480;
      gain_q   <= 16'sd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcf_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i[10:0];
        rcf_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        rcf_pkg::CFG_GAIN:   gain_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign wstart = cfg_we_i && (cfg_idx_i == rcf_pkg::CFG_WIDTH);

  // effective frame geometry
  always_comb begin
    geom.w_eff = (width_q == '0) ? 11'd1 :
                 (width_q > 11'(rcf_pkg::MAX_WIDTH)) ? 11'(rcf_pkg::MAX_WIDTH) : width_q;
    geom.h_eff = (height_q == '0) ? 16'd1 : height_q;
    geom.npix  = rcf_pkg::POS_W'(geom.w_eff * geom.h_eff);
    geom.lag   = {16'd0, geom.w_eff} + 27'd1;
    geom.total = geom.npix + geom.lag;
  end

  assign pending = jq_cnt + {1'b0, back_busy};

  rcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (item_i),
    .geom_i     (geom),
    .wstart_i   (wstart),
    .pending_i  (pending),
    .jq_full_i  (jq_full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .ram_wr_o   (ram_wr)
  );

  rcf_job_queue u_jq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (jq_pop),
    .data_o  (job_out),
    .valid_o (jq_valid),
    .full_o  (jq_full),
    .cnt_o   (jq_cnt)
  );

  rcf_ram #(
    .WIDTH (32),
    .DEPTH (rcf_pkg::RAM_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (jq_valid),
    .job_pop_o   (jq_pop),
    .geom_i      (geom),
    .gain_i      (gain_q),
    .busy_o      (back_busy),
    .ram_raddr_o (raddr),
    .ram_rdata_i (rdata),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

  // checks
  `RCF_ASSERT_NOW(a_jq_no_overflow, job_push, jq_cnt != 2'd2)
  `RCF_ASSERT_NOW(a_w1_no_write_in_flight, ram_wr.we && (pending != 2'd0), geom.w_eff != 11'd1)
  `RCF_ASSERT_NEXT(a_width_write_stalls, wstart && !full, full)

endmodule

// File: hdl/rcf_ram.sv
// ---------------------------------------------------------------------------
// rcf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rcf_front.sv
// ---------------------------------------------------------------------------
// rcf_front: request intake and raster tracking
// Clears the line store after reset, tracks the raster position, writes
// pixels into the line store and queues coefficient and output jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  rcf_pkg::in_item_t item_i,
  input  rcf_pkg::geom_t   geom_i,
  input  logic             wstart_i,
  input  logic [1:0]       pending_i,
  input  logic             jq_full_i,
  output logic             job_push_o,
  output rcf_pkg::job_t    job_o,
  output rcf_pkg::ram_wr_t ram_wr_o
);

  rcf_pkg::front_state_e state_q, state_d;
  logic [rcf_pkg::POS_W-1:0]  p_q, p_d;
  logic [rcf_pkg::ROW_W-1:0]  row_q, row_d;
  logic [rcf_pkg::COL_W-1:0]  col_q, col_d;
  logic [rcf_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic                       wrote_q, wrote_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic [11:0]                rem_q, rem_d;
  logic [rcf_pkg::POS_W-1:0]  quo_q, quo_d;

  logic                       accept, pos_acc, pos_reset, ce_last, ge;
  logic [rcf_pkg::POS_W-1:0]  pe;
  logic [rcf_pkg::ROW_W-1:0]  re;
  logic [rcf_pkg::COL_W-1:0]  ce;
  logic [11:0]                r_shift, r_sub;

  // intake gate: one raster write at most while jobs are in flight
  assign full_o = (state_q != rcf_pkg::F_RUN) || jq_full_i ||
                  ((pending_i != 2'd0) && (wrote_q || (geom_i.w_eff == 11'd1)));
  assign accept = push_i && !full_o;

  // effective position for this request
  assign pos_reset = (p_q >= geom_i.total);
  assign pe        = pos_reset ? '0 : p_q;
  assign re        = pos_reset ? '0 : row_q;
  assign ce        = pos_reset ? '0 : col_q;
  assign ce_last   = (({1'b0, ce} + 11'd1) == geom_i.w_eff);

  // restoring divider step for position to row and column
  assign r_shift = {rem_q[10:0], quo_q[rcf_pkg::POS_W-1]};
  assign ge      = (r_shift >= {1'b0, geom_i.w_eff});
  assign r_sub   = ge ? (r_shift - {1'b0, geom_i.w_eff}) : r_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcf_pkg::F_CLEAR;
      p_q     <= '0;
      row_q   <= '0;
      col_q   <= '0;
      clr_q   <= '0;
      wrote_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      row_q   <= row_d;
      col_q   <= col_d;
      clr_q   <= clr_d;
      wrote_q <= wrote_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // next state, raster update and job build
  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    row_d      = row_q;
    col_d      = col_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    pos_acc    = 1'b0;
    job_push_o = 1'b0;
    job_o      = '0;
    ram_wr_o   = '0;

    case (state_q)
      rcf_pkg::F_CLEAR: begin
        ram_wr_o.we   = 1'b1;
        ram_wr_o.addr = clr_q;
        clr_d         = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = rcf_pkg::F_RUN;
        end
      end
      rcf_pkg::F_DIV: begin
        rem_d = r_sub;
        quo_d = {quo_q[rcf_pkg::POS_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(rcf_pkg::POS_W - 1)) begin
          row_d   = quo_d[rcf_pkg::ROW_W-1:0];
          col_d   = r_sub[rcf_pkg::COL_W-1:0];
          state_d = rcf_pkg::F_RUN;
        end
      end
      rcf_pkg::F_RUN: begin
        if (accept) begin
          case (item_i.kind)
            rcf_pkg::KIND_COEF: begin
              if (item_i.coef_index < 4'(rcf_pkg::TAPS)) begin
                job_push_o     = 1'b1;
                job_o.is_coef  = 1'b1;
                job_o.coef_idx = item_i.coef_index;
                job_o.coef_val = item_i.coef_value;
              end
            end
            rcf_pkg::KIND_PIXEL, rcf_pkg::KIND_FLUSH: begin
              pos_acc = 1'b1;
              if (pe < geom_i.npix) begin
                ram_wr_o.we   = 1'b1;
                ram_wr_o.addr = {re[1:0], ce};
                if (item_i.kind == rcf_pkg::KIND_PIXEL) begin
                  ram_wr_o.data = {item_i.alpha_in, item_i.blue_in,
                                   item_i.green_in, item_i.red_in};
                end
              end
              p_d   = pe + 1'b1;
              col_d = ce_last ? '0 : (ce + 1'b1);
              row_d = ce_last ? (re + 1'b1) : re;
              if (pe >= geom_i.lag) begin
                job_push_o = 1'b1;
                job_o.qrow = re - 17'd1 - {16'd0, (ce == '0)};
                job_o.qcol = (ce == '0) ? 10'(geom_i.w_eff - 11'd1) : (ce - 1'b1);
                job_o.last = (pe == (geom_i.total - 1'b1));
                if (job_o.last) begin
                  p_d   = '0;
                  row_d = '0;
                  col_d = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = rcf_pkg::F_RUN;
      end
    endcase

    // width change: recompute row and column from the position
    if (wstart_i && (state_q != rcf_pkg::F_CLEAR)) begin
      state_d = rcf_pkg::F_DIV;
      cnt_d   = '0;
      rem_d   = '0;
      quo_d   = p_q;
    end

    wrote_d = (pending_i != 2'd0) && (wrote_q || pos_acc);
  end

endmodule

// File: hdl/rcf_job_queue.sv
// ---------------------------------------------------------------------------
// rcf_job_queue: two-entry queue between intake and datapath
// Lets intake and the convolution datapath stall independently.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcf_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rcf_pkg::job_t data_i,
  input  logic          pop_i,
  output rcf_pkg::job_t data_o,
  output logic          valid_o,
  output logic          full_o,
  output logic [1:0]    cnt_o
);

  rcf_pkg::job_t slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign data_o  = slot_q[rptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign cnt_o   = cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/rcf_back.sv
// ---------------------------------------------------------------------------
// rcf_back: convolution datapath and result queue
// Walks the nine window taps through the line store, accumulates R, G and
// B, applies the gain, clamps and queues the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rcf_pkg::job_t               job_i,
  input  logic                        job_valid_i,
  output logic                        job_pop_o,
  input  rcf_pkg::geom_t              geom_i,
  input  logic signed [15:0]          gain_i,
  output logic                        busy_o,
  output logic [rcf_pkg::ADDR_W-1:0]  ram_raddr_o,
  input  logic [31:0]                 ram_rdata_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output rcf_pkg::out_item_t          result_o
);

  rcf_pkg::back_state_e state_q, state_d;
  logic signed [15:0]          coef_q [rcf_pkg::TAPS];
  logic [rcf_pkg::ROW_W-1:0]   jrow_q;
  logic [rcf_pkg::COL_W-1:0]   jcol_q;
  logic                        jlast_q;
  logic [3:0]                  tap_q;
  logic [1:0]                  my_q, mx_q;
  logic                        rd_v_q, centre_q;
  logic signed [15:0]          rd_coef_q;
  logic signed [rcf_pkg::ACC_W-1:0]  acc_q  [3];
  logic signed [rcf_pkg::PROD_W-1:0] prod_q [3];
  logic [7:0]                  alpha_q;
  rcf_pkg::out_item_t          ofifo_q [2];
  logic                        owp_q, orp_q;
  logic [1:0]                  ocnt_q;

  logic                        tap_ok, oush, opop;
  logic [rcf_pkg::ROW_W:0]     ny;
  logic [10:0]                 nx;
  logic [7:0]                  clamp [3];
  rcf_pkg::out_item_t          res;

  // window position of the current tap
  assign ny     = {1'b0, jrow_q} + {16'd0, my_q} - 18'd1;
  assign nx     = {1'b0, jcol_q} + {9'd0, mx_q} - 11'd1;
  assign tap_ok = ((my_q != 2'd0) || (jrow_q != '0)) && (ny < {2'b0, geom_i.h_eff}) &&
                  ((mx_q != 2'd0) || (jcol_q != '0)) && (nx < geom_i.w_eff);
  assign ram_raddr_o = {ny[1:0], nx[rcf_pkg::COL_W-1:0]};

  assign busy_o    = (state_q != rcf_pkg::B_IDLE);
  assign job_pop_o = (state_q == rcf_pkg::B_IDLE) && job_valid_i;
  assign oush      = (state_q == rcf_pkg::B_PUSH) && (ocnt_q != 2'd2);
  assign opop      = pop_i && (ocnt_q != 2'd0);
  assign empty_o   = (ocnt_q == 2'd0);
  assign result_o  = ofifo_q[orp_q];

  // clamp of the scaled sums; negative values clamp to zero, values above 255 to 255
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (prod_q[c] < 0) begin
        clamp[c] = 8'd0;
      end else if (prod_q[c][rcf_pkg::PROD_W-2:rcf_pkg::GAIN_FRAC] > 32'd255) begin
        clamp[c] = 8'd255;
      end else begin
        clamp[c] = prod_q[c][rcf_pkg::GAIN_FRAC+7:rcf_pkg::GAIN_FRAC];
      end
    end
    res.red_out   = clamp[0];
    res.green_out = clamp[1];
    res.blue_out  = clamp[2];
    res.alpha_out = alpha_q;
    res.frame_end = jlast_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcf_pkg::B_IDLE: begin
        if (job_valid_i && !job_i.is_coef) begin
          state_d = rcf_pkg::B_TAP;
        end
      end
      rcf_pkg::B_TAP: begin
        if (tap_q == 4'(rcf_pkg::TAPS - 1)) begin
          state_d = rcf_pkg::B_LAST;
        end
      end
      rcf_pkg::B_LAST:  state_d = rcf_pkg::B_SCALE;
      rcf_pkg::B_SCALE: state_d = rcf_pkg::B_PUSH;
      rcf_pkg::B_PUSH: begin
        if (oush) begin
          state_d = rcf_pkg::B_IDLE;
        end
      end
      default: state_d = rcf_pkg::B_IDLE;
    endcase
  end

  // control registers, kernel store and result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcf_pkg::B_IDLE;
      for (int i = 0; i < rcf_pkg::TAPS; i++) begin
        coef_q[i] <= '0;
      end
      tap_q    <= '0;
      my_q     <= '0;
      mx_q     <= '0;
      rd_v_q   <= 1'b0;
      centre_q <= 1'b0;
      owp_q    <= 1'b0;
      orp_q    <= 1'b0;
      ocnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= (state_q == rcf_pkg::B_TAP) && tap_ok;
      centre_q <= (state_q == rcf_pkg::B_TAP) && (tap_q == 4'd4);
      if (job_pop_o && job_i.is_coef) begin
        coef_q[job_i.coef_idx] <= job_i.coef_val;
      end
      if (state_q == rcf_pkg::B_IDLE) begin
        tap_q <= '0;
        my_q  <= '0;
        mx_q  <= '0;
      end else if (state_q == rcf_pkg::B_TAP) begin
        tap_q <= tap_q + 1'b1;
        if (mx_q == 2'd2) begin
          mx_q <= '0;
          my_q <= my_q + 1'b1;
        end else begin
          mx_q <= mx_q + 1'b1;
        end
      end
      if (oush) begin
        owp_q <= ~owp_q;
      end
      if (opop) begin
        orp_q <= ~orp_q;
      end
      ocnt_q <= ocnt_q + {1'b0, oush} - {1'b0, opop};
    end
  end

  // datapath: multiply-accumulate, gain and result storage
  always_ff @(posedge clk_i) begin
    rd_coef_q <= coef_q[tap_q];
    if (job_pop_o && !job_i.is_coef) begin
      jrow_q  <= job_i.qrow;
      jcol_q  <= job_i.qcol;
      jlast_q <= job_i.last;
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
    end else if (rd_v_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q[c] + rcf_pkg::ACC_W'(rd_coef_q *
                    $signed({1'b0, ram_rdata_i[8*c +: 8]}));
      end
    end
    if (centre_q) begin
      alpha_q <= ram_rdata_i[31:24];
    end
    if (state_q == rcf_pkg::B_SCALE) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= rcf_pkg::PROD_W'(acc_q[c] * gain_i);
      end
    end
    if (oush) begin
      ofifo_q[owp_q] <= res;
    end
  end

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for rgba_convolution_filter
// A directed table, then framed random traffic over several geometry and
// gain settings. Results are checked against table values or an in-bench predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rcf_pkg::*;

  localparam int unsigned SETTLE   = 64;
  localparam int unsigned WD_LIMIT = 20000;

  typedef struct {
    in_item_t  item;
    bit        given;
    out_item_t want;
  } stim_row_t;

  logic      clk_i, rst_ni;
  logic      push, full, empty, pop;
  in_item_t  item_i;
  out_item_t result_o;
  logic      cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  rgba_convolution_filter uut (.*);

  // predictor state
  logic signed [15:0] kern_q[TAPS];
  logic [31:0]        rows_q[4][MAX_WIDTH];
  int unsigned        pos_q;
  logic [10:0]        width_q;
  logic [15:0]        height_q;
  logic signed [15:0] gain_q;

  out_item_t pixel_fifo[$];
  int        n_errors, n_requests, n_results, n_frames, idle_cycles;
  bit        calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  // filter model: returns 1 when the request yields an output pixel
  function automatic bit filter_pixel(input in_item_t it, output out_item_t res);
    int unsigned w, h, npix, lag, total, p, q, qy, qx;
    longint sum, scaled;
    longint ny, nx;
    logic [31:0] word;
    res = '0;
    if (it.kind == KIND_COEF) begin
      if (it.coef_index < TAPS) kern_q[it.coef_index] = it.coef_value;
      return 0;
    end
    if (it.kind == KIND_NONE) return 0;
    w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
    h = (height_q == 0) ? 1 : height_q;
    npix = w * h;
    lag = w + 1;
    total = npix + lag;
    if (pos_q >= total) pos_q = 0;
    p = pos_q;
    if (p < npix)
      rows_q[(p / w) % 4][p % w] = (it.kind == KIND_PIXEL) ?
          {it.alpha_in, it.blue_in, it.green_in, it.red_in} : 32'd0;
    pos_q = p + 1;
    if (p < lag) return 0;
    q = p - lag;
    qy = q / w;
    qx = q % w;
    for (int c = 0; c < 3; c++) begin
      sum = 0;
      for (int my = 0; my < 3; my++) begin
        ny = longint'(qy) + my - 1;
        if (ny < 0 || ny >= h) continue;
        for (int mx = 0; mx < 3; mx++) begin
          nx = longint'(qx) + mx - 1;
          if (nx < 0 || nx >= w) continue;
          word = rows_q[ny % 4][nx];
          sum += longint'(kern_q[mx + my * 3]) * longint'(word[8*c +: 8]);
        end
      end
      scaled = (sum * longint'(gain_q)) / 4096;
      if (scaled < 0) scaled = 0;
      if (scaled > 255) scaled = 255;
      case (c)
        0: res.red_out   = scaled[7:0];
        1: res.green_out = scaled[7:0];
        default: res.blue_out = scaled[7:0];
      endcase
    end
    res.alpha_out = rows_q[qy % 4][qx][31:24];
    res.frame_end = (q == npix - 1);
    if (res.frame_end) pos_q = 0;
    return 1;
  endfunction

  function automatic in_item_t mk(input kind_e k, input logic [31:0] rgba,
                                  input logic [3:0] idx, input logic [15:0] val);
    in_item_t it;
    it.kind = k;
    {it.alpha_in, it.blue_in, it.green_in, it.red_in} = rgba;
    it.coef_index = idx;
    it.coef_value = val;
    return it;
  endfunction

  task automatic cfg_write(input cfg_reg_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH:  width_q = data[10:0];
      CFG_HEIGHT: height_q = data;
      default:    gain_q = data;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one request until accepted; the expected pixel goes in the fifo
  task automatic send_request(input in_item_t it, input bit given = 0,
                              input out_item_t want = '0);
    bit done;
    out_item_t res;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < 15) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        item_i <= it;
        @(posedge clk_i);
        done = !full;
      end
    end
    n_requests++;
    if (filter_pixel(it, res)) pixel_fifo.push_back(given ? want : res);
  endtask

  task automatic drain_wait();
    @(negedge clk_i);
    push <= 1'b0;
    while (pixel_fifo.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // result side: random pop stalls, compare at the rising edge
  always @(negedge clk_i) pop <= calm || ($urandom_range(0, 99) >= 15);

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pixel_fifo.size() == 0) begin
        $display("MISMATCH unexpected result %0h", result_o);
        n_errors++;
      end else begin
        out_item_t w;
        w = pixel_fifo.pop_front();
        if (result_o.red_out !== w.red_out) report_mismatch("red", result_o.red_out, w.red_out);
        if (result_o.green_out !== w.green_out)
          report_mismatch("green", result_o.green_out, w.green_out);
        if (result_o.blue_out !== w.blue_out)
          report_mismatch("blue", result_o.blue_out, w.blue_out);
        if (result_o.alpha_out !== w.alpha_out)
          report_mismatch("alpha", result_o.alpha_out, w.alpha_out);
        if (result_o.frame_end !== w.frame_end)
          report_mismatch("frame_end", result_o.frame_end, w.frame_end);
        if (w.frame_end) n_frames++;
      end
      n_results++;
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("rgba_convolution_filter verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t table_q[$];
    in_item_t  it;
    int unsigned w, h, raster, n;
    logic [15:0] gv;
    push = 0; pop = 0; item_i = '0; calm = 0;
    cfg_we_i = 0; cfg_idx_i = CFG_WIDTH; cfg_wdata_i = '0;
    n_errors = 0; n_requests = 0; n_results = 0; n_frames = 0; idle_cycles = 0;
    foreach (kern_q[i]) kern_q[i] = '0;
    foreach (rows_q[i, j]) rows_q[i][j] = '0;
    pos_q = 0; width_q = 640; height_q = 480; gain_q = 16'sd4096;
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // directed: 2x2 frame, centre tap 1, unit gain
    cfg_write(CFG_WIDTH, 16'd2);
    cfg_write(CFG_HEIGHT, 16'd2);
    cfg_write(CFG_GAIN, 16'd4096);
    table_q.push_back('{mk(KIND_COEF, 0, 4'd4, 16'd1), 0, '0});
    table_q.push_back('{mk(KIND_COEF, 0, 4'd15, 16'h8000), 0, '0});   // out of range tap
    table_q.push_back('{mk(KIND_NONE, 32'hffffffff, 4'd15, 16'hffff), 0, '0});
    table_q.push_back('{mk(KIND_PIXEL, 32'hffffffff, 0, 0), 0, '0});
    table_q.push_back('{mk(KIND_PIXEL, 32'h00000000, 0, 0), 0, '0});
    table_q.push_back('{mk(KIND_PIXEL, 32'h78563412, 0, 0), 0, '0});
    table_q.push_back('{mk(KIND_FLUSH, 0, 0, 0), 1, '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0}});
    table_q.push_back('{mk(KIND_PIXEL, 32'hdeadbeef, 0, 0), 1, '0});  // pixel while draining
    table_q.push_back('{mk(KIND_FLUSH, 0, 0, 0), 1, '{8'h12, 8'h34, 8'h56, 8'h78, 1'b0}});
    table_q.push_back('{mk(KIND_FLUSH, 0, 0, 0), 1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}});
    table_q.push_back('{mk(KIND_COEF, 0, 4'd0, 16'h7fff), 0, '0});
    table_q.push_back('{mk(KIND_COEF, 0, 4'd8, 16'h8000), 0, '0});
    foreach (table_q[i]) send_request(table_q[i].item, table_q[i].given, table_q[i].want);
    drain_wait();

    // random phases over geometry and gain
    for (int ph = 0; ph < 16; ph++) begin
      calm = (ph >= 5 && ph <= 7);
      case (ph)
        0: begin w = 0;    h = 0;     gv = 16'h7fff; end
        1: begin w = 2047; h = 0;     gv = 16'h8000; end
        2: begin w = 3;    h = 65535; gv = 16'd4096; end
        default: begin
          w = $urandom_range(1, 9);
          h = $urandom_range(0, 6);
          case ($urandom_range(0, 2))
            0: gv = 16'd4096;
            1: gv = $urandom_range(0, 2048);
            default: gv = $urandom;
          endcase
        end
      endcase
      cfg_write(CFG_WIDTH, {5'($urandom), w[10:0]});
      cfg_write(CFG_HEIGHT, h[15:0]);
      cfg_write(CFG_GAIN, gv);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h == 0) h = 1;
      n = (ph == 1) ? 2 * w + 4 : ((w * h + w + 1 < 100) ? w * h + w + 1 + $urandom_range(0, 3) : 100);
      raster = 0;
      while (raster < n) begin
        it = in_item_t'({$urandom, $urandom});
        case ($urandom_range(0, 99)) inside
          [0:5]: begin
            it.kind = KIND_COEF;
            if ($urandom_range(0, 1)) it.coef_value = $urandom_range(0, 8) - 4;
          end
          [6:8]: it.kind = KIND_NONE;
          [9:11]: begin it.kind = KIND_FLUSH; raster++; end
          default: begin
            it.kind = (raster < w * h || $urandom_range(0, 9) < 3) ? KIND_PIXEL : KIND_FLUSH;
            raster++;
          end
        endcase
        send_request(it);
      end
      drain_wait();
    end
    calm = 0;

    $display("%0d requests sent, %0d pixels checked, %0d frame ends seen",
             n_requests, n_results, n_frames);
    $display("covered unit, 1024-wide and 65535-high frames and gain extremes");
    if (n_errors == 0 && pixel_fifo.size() == 0)
      $display("rgba_convolution_filter verification clean");
    else
      $display("rgba_convolution_filter verification failed");
    $finish;
  end

endmodule
